// ----- hw/rtl/mh_pkg.sv -----
// Shared types, constants and the arctangent table for the magnetometer heading block.
// Used by every module under hw/rtl; depends on nothing else.
package mh_pkg;

  localparam int CORDIC_STEPS  = 16;
  localparam int FRACTION_BITS = 6;
  localparam int TABLE_LEN     = 24;
  localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  // Axis datapath width: a negated -32768 grown by the CORDIC gain fits in 19 bits.
  localparam int XY_W   = 20;
  // Angle width in units of 2^-16 degree, signed; covers about -100 to +280 degrees.
  localparam int ANG_W  = 26;
  localparam int HEAD_W = 15;

  localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 * 65536);
  localparam logic signed [ANG_W-1:0] ANG_360 = ANG_W'(360 * 65536);

  localparam int RND_SHIFT = 16 - FRACTION_BITS;
  localparam logic [ANG_W-1:0] ROUND_ADD = ANG_W'(1) << (15 - FRACTION_BITS);
  localparam logic [ANG_W-1:0] FULL_TURN = ANG_W'(360) << FRACTION_BITS;

  localparam logic [1:0] KIND_BIG_ENDIAN    = 2'd0;
  localparam logic [1:0] KIND_LITTLE_ENDIAN = 2'd1;
  localparam logic [1:0] KIND_RESET         = 2'd2;

  localparam logic [15:0] OVF_CODE_BE = 16'hF000;  // -4096
  localparam logic [15:0] OVF_CODE_LE = 16'h8000;  // -32768

  localparam int PADDR_W = 3;

  typedef enum logic [1:0] {
    OUTCOME_OK        = 2'd0,
    OUTCOME_NOT_READY = 2'd1,
    OUTCOME_OVERFLOW  = 2'd2,
    OUTCOME_NO_SENSOR = 2'd3
  } outcome_e;

  // atan(2^-i) in units of 2^-16 degree.
  localparam logic signed [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0
  };

  typedef struct packed {
    logic                    valid;
    logic                    zero;
    outcome_e                outcome;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } cordic_t;

endpackage

// ----- hw/rtl/mh_decode.sv -----
// Input stage: decodes the raw readout per sensor kind, checks overflow and
// folds the left half plane. Depends on mh_pkg.
module mh_decode
  import mh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        beat_i,
  input  logic [1:0]  sensor_kind_i,
  input  logic [7:0]  ready_flags_i,
  input  logic [7:0]  data_byte_0_i,
  input  logic [7:0]  data_byte_1_i,
  input  logic [7:0]  data_byte_2_i,
  input  logic [7:0]  data_byte_3_i,
  input  logic [7:0]  data_byte_4_i,
  input  logic [7:0]  data_byte_5_i,
  output cordic_t     stage_o
);

  logic [15:0]            raw_x, raw_y;
  outcome_e               outcome;
  logic signed [XY_W-1:0] sx, sy;
  cordic_t                stage_d, stage_q;

  always_comb begin
    raw_x   = {data_byte_0_i, data_byte_1_i};
    raw_y   = {data_byte_4_i, data_byte_5_i};
    outcome = OUTCOME_OK;
    unique case (sensor_kind_i)
      KIND_BIG_ENDIAN: begin
        if (raw_x == OVF_CODE_BE || raw_y == OVF_CODE_BE) outcome = OUTCOME_OVERFLOW;
      end
      KIND_LITTLE_ENDIAN: begin
        raw_x = {data_byte_1_i, data_byte_0_i};
        raw_y = {data_byte_3_i, data_byte_2_i};
        // The ready check wins over the overflow check.
        if (!ready_flags_i[0]) outcome = OUTCOME_NOT_READY;
        else if (raw_x == OVF_CODE_LE || raw_y == OVF_CODE_LE) outcome = OUTCOME_OVERFLOW;
      end
      default: outcome = OUTCOME_NO_SENSOR;
    endcase

    sx = XY_W'($signed(raw_x));
    sy = XY_W'($signed(raw_y));

    stage_d.valid   = beat_i;
    stage_d.outcome = outcome;
    stage_d.zero    = (raw_x == 16'd0) && (raw_y == 16'd0);
    if (sx < 0) begin
      stage_d.x = -sx;
      stage_d.y = -sy;
      stage_d.z = ANG_180;
    end else begin
      stage_d.x = sx;
      stage_d.y = sy;
      stage_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// ----- hw/rtl/mh_cordic.sv -----
// Vectoring CORDIC pipeline: one micro-rotation per register stage.
// Depends on mh_pkg.
module mh_cordic
  import mh_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cordic_t stage_i,
  output cordic_t stage_o
);

  cordic_t stage_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    cordic_t                 cur, stage_d;
    logic signed [XY_W-1:0]  cx, cy, dx, dy;
    logic signed [ANG_W-1:0] cz;

    if (k == 0) begin : g_first
      assign cur = stage_i;
    end else begin : g_next
      assign cur = stage_q[k-1];
    end

    always_comb begin
      cx = $signed(cur.x);
      cy = $signed(cur.y);
      cz = $signed(cur.z);
      dx = cy >>> k;
      dy = cx >>> k;
      stage_d = cur;
      // Clockwise when y is not negative.
      if (cy >= 0) begin
        stage_d.x = cx + dx;
        stage_d.y = cy - dy;
        stage_d.z = cz + ATAN_TAB[k];
      end else begin
        stage_d.x = cx - dx;
        stage_d.y = cy + dy;
        stage_d.z = cz - ATAN_TAB[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stage_q[k] <= '0;
      end else begin
        stage_q[k] <= stage_d;
      end
    end
  end

  assign stage_o = stage_q[STEPS-1];

endmodule

// ----- hw/rtl/mh_finish.sv -----
// Output stages: wraps the angle into one turn, rounds it to the heading
// resolution and registers the result. Depends on mh_pkg.
module mh_finish
  import mh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cordic_t           stage_i,
  output logic              valid_o,
  output logic [HEAD_W-1:0] heading_o,
  output logic [1:0]        outcome_o
);

  cordic_t                 wrap_d, wrap_q;
  logic signed [ANG_W-1:0] z;
  logic [ANG_W-1:0]        sum, h;
  logic [HEAD_W-1:0]       heading_d, heading_q;
  logic                    valid_q;
  logic [1:0]              outcome_q;

  always_comb begin
    z      = $signed(stage_i.z);
    wrap_d = stage_i;
    if (z < 0) begin
      wrap_d.z = z + ANG_360;
    end else if (z >= ANG_360) begin
      wrap_d.z = z - ANG_360;
    end
  end

  always_comb begin
    sum = wrap_q.z + ROUND_ADD;
    h   = sum >> RND_SHIFT;
    // A heading that rounds up to a full turn reads as zero.
    if (h >= FULL_TURN) h = h - FULL_TURN;
    if (wrap_q.outcome == OUTCOME_OK && !wrap_q.zero) heading_d = h[HEAD_W-1:0];
    else heading_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      wrap_q  <= wrap_d;
      valid_q <= wrap_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    heading_q <= heading_d;
    outcome_q <= wrap_q.outcome;
  end

  assign valid_o   = valid_q;
  assign heading_o = heading_q;
  assign outcome_o = outcome_q;

endmodule

// ----- hw/rtl/magnetometer_heading_top.sv -----
// Top level of the magnetometer heading block: register port and pipeline.
// Depends on mh_pkg, mh_decode, mh_cordic and mh_finish.

// A readout is taken with start at any clock edge; busy is never raised, so one
// beat may enter every cycle. Its result leaves 19 cycles later (one decode stage,
// one stage per CORDIC micro-rotation, two wrap and rounding stages), marked by
// result_valid_o for a single cycle, and the receiver must take it then. Results
// come out in the order the readouts went in. sensor_kind lives at byte address 0
// of the register port and resets to "no sensor"; change it only while no
// readout is in the pipeline.
module magnetometer_heading_top
  import mh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         ready_flags_i,
  input  logic [7:0]         data_byte_0_i,
  input  logic [7:0]         data_byte_1_i,
  input  logic [7:0]         data_byte_2_i,
  input  logic [7:0]         data_byte_3_i,
  input  logic [7:0]         data_byte_4_i,
  input  logic [7:0]         data_byte_5_i,
  output logic               result_valid_o,
  output logic [HEAD_W-1:0]  heading_o,
  output logic [1:0]         outcome_o
);

  logic       reg_sel;
  logic [1:0] sensor_kind_q, sensor_kind_d;
  cordic_t    dec_stage, cordic_stage;

  assign reg_sel = (paddr[PADDR_W-1:2] == '0);
  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign prdata  = reg_sel ? {30'd0, sensor_kind_q} : 32'd0;

  always_comb begin
    sensor_kind_d = sensor_kind_q;
    if (psel && penable && pwrite && reg_sel) sensor_kind_d = pwdata[1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_kind_q <= KIND_RESET;
    end else begin
      sensor_kind_q <= sensor_kind_d;
    end
  end

  mh_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .beat_i        (start),
    .sensor_kind_i (sensor_kind_q),
    .ready_flags_i (ready_flags_i),
    .data_byte_0_i (data_byte_0_i),
    .data_byte_1_i (data_byte_1_i),
    .data_byte_2_i (data_byte_2_i),
    .data_byte_3_i (data_byte_3_i),
    .data_byte_4_i (data_byte_4_i),
    .data_byte_5_i (data_byte_5_i),
    .stage_o       (dec_stage)
  );

  mh_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (dec_stage),
    .stage_o (cordic_stage)
  );

  mh_finish u_finish (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (cordic_stage),
    .valid_o   (result_valid_o),
    .heading_o (heading_o),
    .outcome_o (outcome_o)
  );

endmodule
